// File: src/clipped_glyph_column_renderer_top_defines.svh
// assertion macros for the glyph column renderer checker
// no dependencies
`ifndef CLIPPED_GLYPH_COLUMN_RENDERER_TOP_DEFINES_SVH
`define CLIPPED_GLYPH_COLUMN_RENDERER_TOP_DEFINES_SVH

// same-cycle implication
`define CGCR_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cgcr assertion failed");

// next-cycle implication
`define CGCR_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cgcr assertion failed");

`endif

// File: src/cgcr_pkg.sv
// shared types and constants for the glyph column renderer
// no dependencies
`timescale 1ns / 1ps

package cgcr_pkg;

  localparam int FONT_BYTES_DEF = 4096;
  localparam int GLYPH_GAP      = 1;
  localparam int MAX_GLYPH_DIM  = 16;
  localparam int DIM_CAP        = (MAX_GLYPH_DIM < 16) ? MAX_GLYPH_DIM : 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_DRAW  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LEFT    = 3'd0,
    CFG_CLIP_RIGHT   = 3'd1,
    CFG_CLIP_TOP     = 3'd2,
    CFG_CLIP_BOTTOM  = 3'd3,
    CFG_GLYPH_WIDTH  = 3'd4,
    CFG_GLYPH_HEIGHT = 3'd5,
    CFG_FIRST_CHAR   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CHECK,
    ST_COL
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [11:0]        font_addr;
    logic [7:0]         font_byte;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [7:0]         char_code;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] column_x;
    logic signed [15:0] top_y;
    logic [15:0]        row_mask;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] clip_left;
    logic signed [15:0] clip_right;
    logic signed [15:0] clip_top;
    logic signed [15:0] clip_bottom;
    logic [4:0]         glyph_width;
    logic [4:0]         glyph_height;
    logic [7:0]         first_char;
  } cfg_t;

endpackage

// File: src/cgcr_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps

module cgcr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr0_i,
  input  logic [AddrW-1:0] raddr1_i,
  output logic [Width-1:0] rdata0_o,
  output logic [Width-1:0] rdata1_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata0_q;
  logic [Width-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// File: src/cgcr_cfg.sv
// configuration register file of the glyph column renderer
// depends on cgcr_pkg
`timescale 1ns / 1ps

module cgcr_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cgcr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cgcr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output cgcr_pkg::cfg_t                   cfg_o
);

  cgcr_pkg::cfg_t cfg_q;
  cgcr_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cgcr_pkg::CFG_CLIP_LEFT:    cfg_d.clip_left    = cfg_data_i;
        cgcr_pkg::CFG_CLIP_RIGHT:   cfg_d.clip_right   = cfg_data_i;
        cgcr_pkg::CFG_CLIP_TOP:     cfg_d.clip_top     = cfg_data_i;
        cgcr_pkg::CFG_CLIP_BOTTOM:  cfg_d.clip_bottom  = cfg_data_i;
        cgcr_pkg::CFG_GLYPH_WIDTH:  cfg_d.glyph_width  = cfg_data_i[4:0];
        cgcr_pkg::CFG_GLYPH_HEIGHT: cfg_d.glyph_height = cfg_data_i[4:0];
        cgcr_pkg::CFG_FIRST_CHAR:   cfg_d.first_char   = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_left    <= 16'sd0;
      cfg_q.clip_right   <= 16'sd0;
      cfg_q.clip_top     <= 16'sd0;
      cfg_q.clip_bottom  <= 16'sd0;
      cfg_q.glyph_width  <= 5'd8;
      cfg_q.glyph_height <= 5'd8;
      cfg_q.first_char   <= 8'd32;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/cgcr_engine.sv
// sequencer and column datapath: font store, pen, per-column read and clip
// depends on cgcr_pkg and cgcr_ram
`timescale 1ns / 1ps

module cgcr_engine #(
  parameter int FONT_BYTES = cgcr_pkg::FONT_BYTES_DEF,
  localparam int AddrW = (FONT_BYTES > 1) ? $clog2(FONT_BYTES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cgcr_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  input  cgcr_pkg::in_item_t  in_item_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output cgcr_pkg::out_item_t out_item_o,
  input  logic                out_stall_i
);

  cgcr_pkg::state_e state_q, state_d;

  logic [15:0] pen_x_q, pen_x_d;
  logic [15:0] pen_y_q, pen_y_d;
  logic [15:0] px_q, py_q;
  logic [7:0]  code_q;
  logic [4:0]  w_q, h_q;
  logic [3:0]  col_q, col_d;
  logic [13:0] base_q, base_d;
  logic [5:0]  stride_q, stride_d;
  logic [15:0] vmask_q, vmask_d;
  logic        intab_q, intab_d;

  logic                out_valid_q, out_valid_d;
  cgcr_pkg::out_item_t out_q, out_d;

  logic [4:0]  w_sat, h_sat;
  logic [7:0]  idx;
  logic [17:0] lo, hi, xe, cle, cre;
  logic [16:0] span_end, a0, a1, wa_ext;
  logic [3:0]  rd_col;
  logic        fits, visible, done, can_load, out_load, accept;
  logic        ram_we, ram_re;
  logic [7:0]  rd0, rd1;

  // saturate glyph size to the supported range
  always_comb begin
    w_sat = cfg_i.glyph_width;
    if (cfg_i.glyph_width == 5'd0) w_sat = 5'd1;
    else if (cfg_i.glyph_width > 5'(cgcr_pkg::DIM_CAP)) w_sat = 5'(cgcr_pkg::DIM_CAP);
    h_sat = cfg_i.glyph_height;
    if (cfg_i.glyph_height == 5'd0) h_sat = 5'd1;
    else if (cfg_i.glyph_height > 5'(cgcr_pkg::DIM_CAP)) h_sat = 5'(cgcr_pkg::DIM_CAP);
  end

  // glyph base and vertical clip, set up once per item
  assign idx      = code_q - cfg_i.first_char;
  assign intab_d  = (code_q >= cfg_i.first_char);
  assign stride_d = (h_q > 5'd8) ? {w_q, 1'b0} : {1'b0, w_q};
  assign base_d   = {6'd0, idx} * {8'd0, stride_d};
  assign lo = {{2{cfg_i.clip_top[15]}}, cfg_i.clip_top} - {{2{py_q[15]}}, py_q};
  assign hi = {{2{cfg_i.clip_bottom[15]}}, cfg_i.clip_bottom} - {{2{py_q[15]}}, py_q};

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      vmask_d[j] = ($signed(18'(j)) >= $signed(lo)) && ($signed(18'(j)) < $signed(hi))
                   && (5'(j) < h_q);
    end
  end

  assign span_end = {3'd0, base_q} + {11'd0, stride_q};
  assign fits     = intab_q && (span_end <= 17'(FONT_BYTES));

  // column position against the horizontal clip
  assign xe  = {{2{px_q[15]}}, px_q} + {14'd0, col_q};
  assign cle = {{2{cfg_i.clip_left[15]}}, cfg_i.clip_left};
  assign cre = {{2{cfg_i.clip_right[15]}}, cfg_i.clip_right};
  assign visible = ($signed(xe) >= $signed(cle)) && ($signed(xe) < $signed(cre));
  assign done    = ({1'b0, col_q} == (w_q - 5'd1)) || ($signed(xe + 18'd1) >= $signed(cre));
  assign can_load = !out_valid_q || !out_stall_i;

  assign a0     = {3'd0, base_q} + {13'd0, rd_col};
  assign a1     = a0 + {12'd0, w_q};
  assign wa_ext = {5'd0, in_item_i.font_addr};
  assign accept = in_valid_i && (state_q == cgcr_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    pen_x_d     = pen_x_q;
    pen_y_d     = pen_y_q;
    col_d       = col_q;
    rd_col      = col_q + 4'd1;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      cgcr_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_item_i.operation)
            cgcr_pkg::OP_LOAD: begin
              ram_we = (wa_ext < 17'(FONT_BYTES));
            end
            cgcr_pkg::OP_BEGIN: begin
              pen_x_d = in_item_i.start_x;
              pen_y_d = in_item_i.start_y;
            end
            cgcr_pkg::OP_DRAW: begin
              pen_x_d = pen_x_q + {11'd0, w_sat} + 16'(cgcr_pkg::GLYPH_GAP);
              state_d = cgcr_pkg::ST_SETUP;
            end
            default: ;
          endcase
        end
      end
      cgcr_pkg::ST_SETUP: begin
        state_d = cgcr_pkg::ST_CHECK;
      end
      cgcr_pkg::ST_CHECK: begin
        if (fits) begin
          rd_col  = 4'd0;
          col_d   = 4'd0;
          ram_re  = 1'b1;
          state_d = cgcr_pkg::ST_COL;
        end else begin
          state_d = cgcr_pkg::ST_IDLE;
        end
      end
      cgcr_pkg::ST_COL: begin
        if (!visible || can_load) begin
          out_load = visible;
          if (done) begin
            state_d = cgcr_pkg::ST_IDLE;
          end else begin
            col_d  = col_q + 4'd1;
            ram_re = 1'b1;
          end
        end
      end
      default: state_d = cgcr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_d.column_x = xe[15:0];
    out_d.top_y    = py_q;
    out_d.row_mask = {rd1, rd0} & vmask_q;
    out_d.last     = done;
    out_valid_d    = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cgcr_pkg::ST_IDLE;
      pen_x_q     <= 16'd0;
      pen_y_q     <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_item_i.operation == cgcr_pkg::OP_DRAW)) begin
      px_q   <= pen_x_q;
      py_q   <= pen_y_q;
      code_q <= in_item_i.char_code;
      w_q    <= w_sat;
      h_q    <= h_sat;
    end
    if (state_q == cgcr_pkg::ST_SETUP) begin
      base_q   <= base_d;
      stride_q <= stride_d;
      vmask_q  <= vmask_d;
      intab_q  <= intab_d;
    end
    col_q <= col_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  cgcr_ram #(
    .Width (8),
    .Depth (FONT_BYTES)
  ) u_font (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (wa_ext[AddrW-1:0]),
    .wdata_i  (in_item_i.font_byte),
    .re_i     (ram_re),
    .raddr0_i (a0[AddrW-1:0]),
    .raddr1_i (a1[AddrW-1:0]),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  assign in_stall_o  = (state_q != cgcr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: src/clipped_glyph_column_renderer_top.sv
// top level of the clipped glyph column renderer
// depends on cgcr_pkg, cgcr_cfg, cgcr_engine
// channel | signals                           | direction
// cfg     | cfg_we_i, cfg_idx_i, cfg_data_i   | write only
// in      | in_valid_i, in_item_i, in_stall_o | item in
// out     | out_valid_o, out_item_o, out_stall_i | item out
// load, begin and unused operations leave the input free to take the next item
// a draw passes the setup and check states, then scans glyph columns one by one, up to width 16,
// reading each column through the single read port pair of the font ram
// a stalled output holds the column sequencer on the next visible column
// reset clears pen and clip settings and sets glyph size 8 and first char 32; the font ram holds no reset value
`timescale 1ns / 1ps

module clipped_glyph_column_renderer_top #(
  parameter int FONT_BYTES = cgcr_pkg::FONT_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cgcr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cgcr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  cgcr_pkg::in_item_t              in_item_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output cgcr_pkg::out_item_t             out_item_o,
  input  logic                            out_stall_i
);

  cgcr_pkg::cfg_t cfg;

  cgcr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  cgcr_engine #(
    .FONT_BYTES (FONT_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: src/cgcr_checker.sv
// port-level checker for the glyph column renderer, bound to the top level
// depends on cgcr_pkg and clipped_glyph_column_renderer_top_defines.svh
`timescale 1ns / 1ps
`include "clipped_glyph_column_renderer_top_defines.svh"

module cgcr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic                            in_valid_i,
  input cgcr_pkg::in_item_t              in_item_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input cgcr_pkg::out_item_t             out_item_o,
  input logic                            out_stall_i
);

  logic in_acc;
  logic draw_acc;
  logic short_acc;
  logic out_hold;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign draw_acc  = in_acc && (in_item_i.operation == cgcr_pkg::OP_DRAW);
  assign short_acc = in_acc && (in_item_i.operation != cgcr_pkg::OP_DRAW);
  assign out_hold  = out_valid_o && out_stall_i;

  // a stalled output item holds
  `CGCR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_hold, out_valid_o && $stable(out_item_o))
  // a draw item keeps the input side busy
  `CGCR_ASSERT_NXT(a_draw_busy, clk_i, rst_ni, draw_acc, in_stall_o)
  // load, begin and unused operations leave the input side free in the next cycle
  `CGCR_ASSERT_NXT(a_short_op, clk_i, rst_ni, short_acc, !in_stall_o)
  // no output item appears while idle with an empty output
  `CGCR_ASSERT_NXT(a_no_spurious, clk_i, rst_ni, !in_stall_o && !out_valid_o, !out_valid_o)
  // configuration is written only with nothing in flight
  `CGCR_ASSERT_IMP(a_cfg_quiet, clk_i, rst_ni, cfg_we_i, !in_stall_o && !out_valid_o)

endmodule

bind clipped_glyph_column_renderer_top cgcr_checker u_cgcr_checker (.*);
